// File: src/osm_pkg.sv
// Shared types and constants for the order statistic multiset.
// Holds command codes, sizing constants, the cell control word and the group result.
// No dependencies.
`default_nettype none

package osm_pkg;

    // Sizing of the cell row.
    localparam int CAPACITY = 256;
    localparam int GROUP    = 16;
    localparam int GROUP_W  = $clog2(GROUP);
    localparam int NGROUPS  = (CAPACITY + GROUP - 1) / GROUP;
    localparam int NCELLS   = NGROUPS * GROUP;
    localparam int IDX_W    = $clog2(NCELLS);
    localparam int OCC_W    = $clog2(CAPACITY + 1);

    // Answers used when there is no value to return.
    localparam logic [31:0] TOP_VALUE = 32'h7fff_ffff;
    localparam logic [31:0] BOT_VALUE = 32'h8000_0001;

    // Command codes.
    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_RANK   = 3'd2;
    localparam logic [2:0] CMD_SELECT = 3'd3;
    localparam logic [2:0] CMD_PRED   = 3'd4;
    localparam logic [2:0] CMD_SUCC   = 3'd5;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_GROUP,
        S_GLOBAL,
        S_COMMIT
    } state_t;

    // Control word broadcast to every cell.
    typedef struct packed {
        logic [2:0]       cmd;
        logic [31:0]      operand;
        logic             k_ok;
        logic [IDX_W-1:0] k_idx;
        logic             upd_ins;
        logic             upd_rem;
    } ctrl_t;

    // Registered reduction result of one group of cells.
    typedef struct packed {
        logic               hit;
        logic [31:0]        value;
        logic [GROUP_W-1:0] loc;
    } grp_res_t;

endpackage

`default_nettype wire

// File: src/osm_cell.sv
// One cell of the sorted row: a stored value with its valid bit.
// Compares against the broadcast operand and shifts to or from its neighbors.
// Depends on osm_pkg.
`default_nettype none

module osm_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire osm_pkg::ctrl_t            ctrl,
    input  wire logic [osm_pkg::IDX_W-1:0] idx,
    input  wire logic [31:0]               l_val,
    input  wire logic                      l_vld,
    input  wire logic                      l_lt,
    input  wire logic                      l_le,
    input  wire logic [31:0]               r_val,
    input  wire logic                      r_vld,
    input  wire logic                      r_lt,
    output logic [31:0]                    val,
    output logic                           vld,
    output logic                           lt,
    output logic                           le,
    output logic                           sel
);
    import osm_pkg::*;

    logic [31:0] val_reg;
    logic [31:0] val_next;
    logic        vld_reg;
    logic        vld_next;
    logic        eq;

    // Compare the stored value with the operand.
    always_comb
    begin
        lt = vld_reg && ($signed(val_reg) < $signed(ctrl.operand));
        le = vld_reg && ($signed(val_reg) <= $signed(ctrl.operand));
        eq = vld_reg && (val_reg == ctrl.operand);
    end

    // Mark this cell when it holds the word the command looks for.
    always_comb
    begin
        unique case (ctrl.cmd)
            CMD_REMOVE: sel = !lt && l_lt && eq;
            CMD_RANK:   sel = lt && !r_lt;
            CMD_SELECT: sel = ctrl.k_ok && (idx == ctrl.k_idx);
            CMD_PRED:   sel = lt && !r_lt;
            CMD_SUCC:   sel = vld_reg && !le && l_le;
            default:    sel = 1'b0;
        endcase
    end

    // Insert shifts larger values right; remove closes the gap from the right.
    always_comb
    begin
        val_next = val_reg;
        vld_next = vld_reg;
        if (ctrl.upd_ins && !le)
        begin
            val_next = l_le ? ctrl.operand : l_val;
            vld_next = vld_reg || l_vld;
        end
        else if (ctrl.upd_rem && !lt)
        begin
            val_next = r_val;
            vld_next = r_vld;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;
    assign vld = vld_reg;

endmodule

`default_nettype wire

// File: src/osm_group.sv
// Registered reduction over one group of cells.
// Picks the value and local index of the one marked cell, if any.
// Depends on osm_pkg.
`default_nettype none

module osm_group (
    input  wire logic                          clk,
    input  wire logic [osm_pkg::GROUP-1:0]     sel,
    input  wire logic [osm_pkg::GROUP*32-1:0]  values,
    output osm_pkg::grp_res_t                  res
);
    import osm_pkg::*;

    grp_res_t res_reg;
    grp_res_t res_next;

    // At most one cell is marked, so an OR of the gated words selects it.
    always_comb
    begin
        res_next = '0;
        for (int i = 0; i < GROUP; i++)
        begin
            if (sel[i])
            begin
                res_next.hit   = 1'b1;
                res_next.value = res_next.value | values[i*32 +: 32];
                res_next.loc   = res_next.loc | GROUP_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// File: src/order_statistic_multiset.sv
// Top level of the order statistic multiset: a sorted row of cells,
// a two-level registered reduction, the command sequencer and the output register.
// Depends on osm_pkg, osm_cell and osm_group.
//
//  Channel | Dir | Signals                        | Contents
//  s_      | in  | tvalid tready tdata[31:0] tuser[2:0] | operand; cmd in tuser
//  m_      | out | tvalid tready tdata[31:0] tuser[1:0] | answer; status in tuser
//
// Every command passes through accept, group reduction, global reduction and commit, in that order.
// The group and global steps are the two registered reduction levels over the row of cells.
// The commit cycle waits while the previous result word has not been taken.
// Reset empties the row (all valid bits clear) and the occupancy count; no clearing pass.
`default_nettype none

module order_statistic_multiset (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] operand
    input  wire logic [2:0]  s_tuser,   // [2:0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] answer
    output logic [1:0]       m_tuser    // [1:0] status
);
    import osm_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [2:0]       cmd_reg;
    logic [31:0]      x_reg;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             m_valid_reg;
    logic [31:0]      ans_reg;
    logic [1:0]       status_reg;
    logic             glb_hit_reg;
    logic [31:0]      glb_val_reg;
    logic [IDX_W-1:0] glb_idx_reg;
    logic             glb_hit_next;
    logic [31:0]      glb_val_next;
    logic [IDX_W-1:0] glb_idx_next;

    logic             accept;
    logic             commit;
    logic             full;
    logic [31:0]      x_minus1;
    ctrl_t            ctrl;
    logic [31:0]      ans_next;
    logic [1:0]       status_next;

    logic [31:0]              cell_val [NCELLS];
    logic                     cell_vld [NCELLS];
    logic                     cell_lt  [NCELLS];
    logic                     cell_le  [NCELLS];
    logic [NCELLS-1:0]        sel_vec;
    logic [NCELLS*32-1:0]     val_vec;
    grp_res_t                 grp_res  [NGROUPS];

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_tvalid) state_next = S_GROUP;
            S_GROUP:  state_next = S_GLOBAL;
            S_GLOBAL: state_next = S_COMMIT;
            S_COMMIT: if (!m_valid_reg || m_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        s_tready = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            S_IDLE:   s_tready = 1'b1;
            S_COMMIT: commit   = !m_valid_reg || m_tready;
            default:  ;
        endcase
    end

    assign accept = s_tvalid && s_tready;
    assign full   = (occ_reg == OCC_W'(CAPACITY));

    // Control word for the cells.
    always_comb
    begin
        x_minus1     = x_reg - 32'd1;
        ctrl.cmd     = cmd_reg;
        ctrl.operand = x_reg;
        ctrl.k_ok    = !x_reg[31] && (x_reg != 32'd0) && (x_reg <= 32'(occ_reg));
        ctrl.k_idx   = x_minus1[IDX_W-1:0];
        ctrl.upd_ins = commit && (cmd_reg == CMD_INSERT) && !full;
        ctrl.upd_rem = commit && (cmd_reg == CMD_REMOVE) && glb_hit_reg;
    end

    // The row of cells; the ends see a virtual minimum on the left and an empty cell on the right.
    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        logic [31:0] l_val;
        logic        l_vld;
        logic        l_lt;
        logic        l_le;
        logic [31:0] r_val;
        logic        r_vld;
        logic        r_lt;
        logic        sel;

        if (i == 0)
        begin : g_left_end
            assign l_val = '0;
            assign l_vld = 1'b1;
            assign l_lt  = 1'b1;
            assign l_le  = 1'b1;
        end
        else
        begin : g_left
            assign l_val = cell_val[i-1];
            assign l_vld = cell_vld[i-1];
            assign l_lt  = cell_lt[i-1];
            assign l_le  = cell_le[i-1];
        end

        if (i == NCELLS - 1)
        begin : g_right_end
            assign r_val = '0;
            assign r_vld = 1'b0;
            assign r_lt  = 1'b0;
        end
        else
        begin : g_right
            assign r_val = cell_val[i+1];
            assign r_vld = cell_vld[i+1];
            assign r_lt  = cell_lt[i+1];
        end

        osm_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .idx   (IDX_W'(i)),
            .l_val (l_val),
            .l_vld (l_vld),
            .l_lt  (l_lt),
            .l_le  (l_le),
            .r_val (r_val),
            .r_vld (r_vld),
            .r_lt  (r_lt),
            .val   (cell_val[i]),
            .vld   (cell_vld[i]),
            .lt    (cell_lt[i]),
            .le    (cell_le[i]),
            .sel   (sel)
        );

        assign sel_vec[i]         = sel;
        assign val_vec[i*32 +: 32] = cell_val[i];
    end

    // First reduction level, one unit per group of cells.
    for (genvar g = 0; g < NGROUPS; g++)
    begin : g_group
        osm_group u_group (
            .clk    (clk),
            .sel    (sel_vec[g*GROUP +: GROUP]),
            .values (val_vec[g*GROUP*32 +: GROUP*32]),
            .res    (grp_res[g])
        );
    end

    // Second reduction level across the groups.
    always_comb
    begin
        glb_hit_next = 1'b0;
        glb_val_next = '0;
        glb_idx_next = '0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            if (grp_res[g].hit)
            begin
                glb_hit_next = 1'b1;
                glb_val_next = glb_val_next | grp_res[g].value;
                glb_idx_next = glb_idx_next | (IDX_W'(g * GROUP) + IDX_W'(grp_res[g].loc));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        glb_hit_reg <= glb_hit_next;
        glb_val_reg <= glb_val_next;
        glb_idx_reg <= glb_idx_next;
    end

    // Result word for the command.
    always_comb
    begin
        ans_next    = '0;
        status_next = ST_OK;
        unique case (cmd_reg)
            CMD_INSERT:
            begin
                status_next = full ? ST_FULL : ST_OK;
            end
            CMD_REMOVE:
            begin
                status_next = glb_hit_reg ? ST_OK : ST_NONE;
            end
            CMD_RANK:
            begin
                ans_next = glb_hit_reg ? (32'(glb_idx_reg) + 32'd2) : 32'd1;
            end
            CMD_SELECT, CMD_SUCC:
            begin
                ans_next    = glb_hit_reg ? glb_val_reg : TOP_VALUE;
                status_next = glb_hit_reg ? ST_OK : ST_NONE;
            end
            CMD_PRED:
            begin
                ans_next    = glb_hit_reg ? glb_val_reg : BOT_VALUE;
                status_next = glb_hit_reg ? ST_OK : ST_NONE;
            end
            default: ;
        endcase
    end

    // Occupancy follows the committed updates.
    always_comb
    begin
        occ_next = occ_reg;
        if (ctrl.upd_ins)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (ctrl.upd_rem)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            if (commit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Command and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= s_tuser;
            x_reg   <= s_tdata;
        end
        if (commit)
        begin
            ans_reg    <= ans_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = ans_reg;
    assign m_tuser  = status_reg;

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the order statistic multiset.
// It runs a directed table and four random phases, and checks every result word against a predictor or a typed answer.
// Depends on osm_pkg and order_statistic_multiset.
`timescale 1ns / 100ps

module testbench;
    import osm_pkg::*;

    // Command codes that the block does not define; they must leave the set alone.
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    localparam int DIR_ROWS        = 25;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int HOLD_AT_RESULT  = 120;
    localparam int HOLD_CYCLES     = 60;
    localparam int DRAIN_LIMIT     = 5000;

    // One row of the directed table. Where fixed is set, the typed answer is expected.
    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] operand;
        logic        fixed;
        logic [31:0] answer;
        logic [1:0]  status;
    } dir_row_t;

    typedef struct packed {
        logic [31:0] answer;
        logic [1:0]  status;
    } result_word_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] operand
    logic [2:0]  s_tuser  = '0;   // [2:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] answer
    logic [1:0]  m_tuser;         // [1:0] status

    // Sorted copy of the stored values, and results still owed by the block.
    logic signed [31:0] stored_q[$];
    result_word_t       pending_results[$];

    int mismatch_count = 0;
    int results_taken  = 0;
    int idle_phase     = 0;

    // Per phase: percent of idle cycles at the sender, stall cycles at the receiver,
    // and the command mix that steers the occupancy up, to full, and back down.
    int send_idle_pct[4] = '{0, 71, 0, 8};
    int recv_idle_pct[4] = '{0, 0, 71, 8};
    int insert_pct[4]    = '{55, 90, 60, 10};
    int remove_pct[4]    = '{10, 5, 15, 60};

    dir_row_t directed_rows [DIR_ROWS] = '{
        // Empty set right after reset.
        '{CMD_RANK,   32'd5,          1'b1, 32'd1,        ST_OK},
        '{CMD_SELECT, 32'd1,          1'b1, TOP_VALUE,    ST_NONE},
        '{CMD_PRED,   32'd0,          1'b1, BOT_VALUE,    ST_NONE},
        '{CMD_SUCC,   32'd0,          1'b1, TOP_VALUE,    ST_NONE},
        '{CMD_REMOVE, 32'd5,          1'b1, 32'd0,        ST_NONE},
        // Both extremes and a duplicated zero.
        '{CMD_INSERT, 32'h8000_0000,  1'b1, 32'd0,        ST_OK},
        '{CMD_INSERT, 32'h7fff_ffff,  1'b1, 32'd0,        ST_OK},
        '{CMD_INSERT, 32'd0,          1'b1, 32'd0,        ST_OK},
        '{CMD_INSERT, 32'd0,          1'b1, 32'd0,        ST_OK},
        '{CMD_RANK,   32'd0,          1'b1, 32'd2,        ST_OK},
        '{CMD_RANK,   32'd1,          1'b1, 32'd4,        ST_OK},
        '{CMD_SELECT, 32'd1,          1'b1, 32'h8000_0000, ST_OK},
        '{CMD_SELECT, 32'd4,          1'b1, 32'h7fff_ffff, ST_OK},
        // Select with k past the end, negative, and zero.
        '{CMD_SELECT, 32'd5,          1'b1, TOP_VALUE,    ST_NONE},
        '{CMD_SELECT, 32'hffff_ffff,  1'b1, TOP_VALUE,    ST_NONE},
        '{CMD_SELECT, 32'd0,          1'b1, TOP_VALUE,    ST_NONE},
        // Nothing below the minimum, nothing above the maximum.
        '{CMD_PRED,   32'h8000_0000,  1'b1, BOT_VALUE,    ST_NONE},
        '{CMD_SUCC,   32'h7fff_ffff,  1'b1, TOP_VALUE,    ST_NONE},
        '{CMD_PRED,   32'd0,          1'b1, 32'h8000_0000, ST_OK},
        '{CMD_SUCC,   32'd0,          1'b1, 32'h7fff_ffff, ST_OK},
        '{CMD_SPARE6, 32'h5a5a_5a5a,  1'b1, 32'd0,        ST_OK},
        '{CMD_SPARE7, 32'ha5a5_a5a5,  1'b1, 32'd0,        ST_OK},
        '{CMD_REMOVE, 32'd0,          1'b1, 32'd0,        ST_OK},
        '{CMD_SUCC,   32'hdead_beef,  1'b0, 32'd0,        ST_OK},
        '{CMD_RANK,   32'h1234_5678,  1'b0, 32'd0,        ST_OK}
    };

    order_statistic_multiset uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog for a hung run.
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Number of stored values strictly smaller than v.
    function automatic int count_below(input logic signed [31:0] v);
        int n;
        n = 0;
        foreach (stored_q[i])
            if (stored_q[i] < v)
                n++;
        return n;
    endfunction

    // Number of stored values smaller than or equal to v.
    function automatic int count_up_to(input logic signed [31:0] v);
        int n;
        n = 0;
        foreach (stored_q[i])
            if (stored_q[i] <= v)
                n++;
        return n;
    endfunction

    // Applies one command to the sorted copy and returns the result word it gives.
    function automatic result_word_t multiset_apply(input logic [2:0] cmd,
                                                    input logic signed [31:0] v);
        result_word_t r;
        int pos;
        r.answer = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_INSERT:
            begin
                if (stored_q.size() >= CAPACITY)
                    r.status = ST_FULL;
                else
                    stored_q.insert(count_up_to(v), v);
            end
            CMD_REMOVE:
            begin
                pos = count_below(v);
                if (pos < stored_q.size() && stored_q[pos] == v)
                    stored_q.delete(pos);
                else
                    r.status = ST_NONE;
            end
            CMD_RANK:
                r.answer = count_below(v) + 1;
            CMD_SELECT:
            begin
                if (v >= 1 && v <= stored_q.size())
                begin
                    r.answer = stored_q[v - 1];
                end
                else
                begin
                    r.answer = TOP_VALUE;
                    r.status = ST_NONE;
                end
            end
            CMD_PRED:
            begin
                pos = count_below(v);
                if (pos > 0)
                begin
                    r.answer = stored_q[pos - 1];
                end
                else
                begin
                    r.answer = BOT_VALUE;
                    r.status = ST_NONE;
                end
            end
            CMD_SUCC:
            begin
                pos = count_up_to(v);
                if (pos < stored_q.size())
                begin
                    r.answer = stored_q[pos];
                end
                else
                begin
                    r.answer = TOP_VALUE;
                    r.status = ST_NONE;
                end
            end
            default:
                r.status = ST_OK;
        endcase
        return r;
    endfunction

    // Random operand: mostly a narrow band so that copies collide, some stored values,
    // some full-width patterns and the extremes.
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (stored_q.size() > 0 && r < 20)
            return stored_q[$urandom_range(stored_q.size() - 1)];
        if (r < 65)
            return 32'($signed($urandom_range(40)) - 20);
        if (r < 88)
            return $urandom;
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h8000_0001;
            2:       return 32'h7fff_fffe;
            default: return 32'h7fff_ffff;
        endcase
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        $display("%0t: mismatch in %s: expected %h, got %h", $realtime, what, want, got);
        mismatch_count++;
    endtask

    // Offers one word, waits for it to be taken, and records the result it must give.
    task automatic offer_word(input logic [2:0] cmd, input logic [31:0] operand,
                              input logic fixed, input logic [31:0] fixed_answer,
                              input logic [1:0] fixed_status);
        result_word_t predicted;
        while ($urandom_range(99) < send_idle_pct[idle_phase])
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= operand;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = multiset_apply(cmd, operand);
        if (fixed)
        begin
            predicted.answer = fixed_answer;
            predicted.status = fixed_status;
        end
        pending_results.push_back(predicted);
    endtask

    // Result side: ready pattern, one long hold-off, and the comparison.
    initial
    begin
        int hold_left;
        result_word_t want;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                results_taken++;
                if (pending_results.size() == 0)
                begin
                    flag_mismatch("unexpected word", 32'd0, m_tdata);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata !== want.answer)
                        flag_mismatch("answer", want.answer, m_tdata);
                    if (m_tuser !== want.status)
                        flag_mismatch("status", 32'(want.status), 32'(m_tuser));
                end
                if (results_taken == HOLD_AT_RESULT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct[idle_phase]);
            end
        end
    end

    // Stimulus: reset, the directed table, four random phases, then the drain.
    initial
    begin
        logic [2:0]  cmd;
        logic [31:0] operand;
        int          r;
        int          waited;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_word(directed_rows[i].cmd, directed_rows[i].operand, directed_rows[i].fixed,
                       directed_rows[i].answer, directed_rows[i].status);

        for (int phase = 0; phase < 4; phase++)
        begin
            idle_phase = phase;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Command mix of this phase.
                r = $urandom_range(99);
                if (r < insert_pct[phase])
                    cmd = CMD_INSERT;
                else if (r < insert_pct[phase] + remove_pct[phase])
                    cmd = CMD_REMOVE;
                else if (r < 98)
                    cmd = 3'($urandom_range(CMD_RANK, CMD_SUCC));
                else
                    cmd = $urandom_range(1) ? CMD_SPARE7 : CMD_SPARE6;

                // Operand suited to the command.
                if (cmd == CMD_SELECT)
                begin
                    if ($urandom_range(99) < 85)
                        operand = $urandom_range(stored_q.size() + 2);
                    else
                        operand = $urandom;
                end
                else if (cmd == CMD_REMOVE && stored_q.size() > 0 && $urandom_range(99) < 60)
                begin
                    operand = stored_q[$urandom_range(stored_q.size() - 1)];
                end
                else
                begin
                    operand = pick_value();
                end
                offer_word(cmd, operand, 1'b0, 32'd0, ST_OK);
            end
        end
        s_tvalid <= 1'b0;

        // Wait for every owed word, then keep the clock running to catch strays.
        waited = 0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
            waited++;
            if (waited > DRAIN_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
